### rtl/rrc_pkg.sv
package rrc_pkg;

    localparam int KEY_W        = 64;
    localparam int DRAW_W       = 16;
    localparam int CFG_W        = 7;
    localparam int SLOT_OUT_W   = 6;
    localparam int BITS_PER_CYC = 4;
    localparam int MOD_CYC      = DRAW_W / BITS_PER_CYC;
    localparam int MOD_CNT_W    = $clog2(MOD_CYC);
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 72;
    localparam int M_TUSER_W    = 2;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    // Probe token that walks the cell chain
    typedef struct packed {
        logic              hit;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  victim_key;
    } t_probe;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

### rtl/rrc_mod.sv
module rrc_mod #(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rrc_pkg::DRAW_W-1:0]         i_draw,
    input  logic [$clog2(CAPACITY):0]          i_cap,
    output logic                               o_done,
    output logic [$clog2(CAPACITY)-1:0]        o_rem
);

    localparam int SW = $clog2(CAPACITY);

    logic                              r_busy;
    logic                              r_done;
    logic [rrc_pkg::MOD_CNT_W-1:0]     r_cnt;
    logic [rrc_pkg::DRAW_W-1:0]        r_draw;
    logic [SW-1:0]                     r_rem;
    logic [SW-1:0]                     n_rem;

    // Restoring remainder, several draw bits per cycle, MSB first
    always_comb begin
        logic [SW:0] t;
        n_rem = r_rem;
        for (int k = 0; k < rrc_pkg::BITS_PER_CYC; k++) begin
            t = {n_rem, r_draw[rrc_pkg::DRAW_W-1-k]};
            if (t >= i_cap) begin
                t = t - i_cap;
            end
            n_rem = t[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rrc_pkg::MOD_CNT_W'(rrc_pkg::MOD_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_draw <= i_draw;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_draw <= r_draw << rrc_pkg::BITS_PER_CYC;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### rtl/rrc_cell.sv
module rrc_cell #(
    parameter int CAPACITY = 64,
    parameter int IDX      = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  rrc_pkg::t_probe                   i_tok,
    input  logic [$clog2(CAPACITY)-1:0]       i_slot,
    input  logic [$clog2(CAPACITY):0]         i_occ,
    input  logic [$clog2(CAPACITY)-1:0]       i_victim,
    input  logic                              i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0]       i_wr_slot,
    input  logic [rrc_pkg::KEY_W-1:0]         i_wr_key,
    output logic                              o_vld,
    output rrc_pkg::t_probe                   o_tok,
    output logic [$clog2(CAPACITY)-1:0]       o_slot
);

    localparam int SW = $clog2(CAPACITY);
    localparam logic [SW-1:0] MY_SLOT = SW'(IDX);
    localparam logic [SW:0]   MY_POS  = (SW+1)'(IDX);

    logic [rrc_pkg::KEY_W-1:0] r_key;
    logic                      r_vld;
    rrc_pkg::t_probe           r_tok;
    rrc_pkg::t_probe           n_tok;
    logic [SW-1:0]             r_slot;
    logic [SW-1:0]             n_slot;
    logic                      w_in_use;
    logic                      w_match;

    assign w_in_use = (MY_POS < i_occ);
    assign w_match  = w_in_use && (r_key == i_tok.key) && !i_tok.hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_slot == MY_SLOT)) begin
            r_key <= i_wr_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Compare, pick up the victim key on the way, pass the token on
    always_comb begin
        n_tok  = i_tok;
        n_slot = i_slot;
        if (w_match) begin
            n_tok.hit = 1'b1;
            n_slot    = MY_SLOT;
        end
        if (i_victim == MY_SLOT) begin
            n_tok.victim_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok  <= n_tok;
        r_slot <= n_slot;
    end

    assign o_vld  = r_vld;
    assign o_tok  = r_tok;
    assign o_slot = r_slot;

endmodule

### rtl/random_replacement_cache.sv
// One item at a time: no new input is accepted until the previous result is loaded for output;
// the probe walks the cell chain one cell per cycle, after the victim remainder is computed
// 4 draw bits per cycle.
// Reset (synchronous, active low): occupancy cleared, capacity register set to 64,
// sequencer idle, no output pending. Stored keys are not cleared.
module random_replacement_cache #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [rrc_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,  // key[63:0], random_draw[79:64]
    // master side
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [rrc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,  // evicted_key[63:0], slot_used[69:64]
    output logic [rrc_pkg::M_TUSER_W-1:0]     o_m_axis_tuser,  // hit[0], evicted[1]
    // configuration: capacity_in_use
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rrc_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int SW    = $clog2(CAPACITY);
    localparam int OW    = SW + 1;
    localparam int CMP_W = (OW > rrc_pkg::CFG_W) ? OW : rrc_pkg::CFG_W;
    localparam int XW    = (SW > rrc_pkg::SLOT_OUT_W) ? SW : rrc_pkg::SLOT_OUT_W;

    rrc_pkg::t_state                r_state;
    rrc_pkg::t_state                n_state;

    logic [rrc_pkg::KEY_W-1:0]      r_key;
    logic [rrc_pkg::CFG_W-1:0]      r_cap;
    logic [OW-1:0]                  r_occ;

    logic                           r_res_hit;
    logic                           r_res_evict;
    logic [rrc_pkg::KEY_W-1:0]      r_res_evkey;
    logic [SW-1:0]                  r_res_slot;

    logic                           r_m_vld;
    logic [rrc_pkg::M_TDATA_W-1:0]  r_m_data;
    logic [rrc_pkg::M_TUSER_W-1:0]  r_m_user;

    logic                           w_accept;
    logic                           w_launch;
    logic                           w_out_load;
    logic                           w_mod_done;
    logic [SW-1:0]                  w_victim;

    logic [CMP_W-1:0]               w_cfg_ext;
    logic [CMP_W-1:0]               w_cap_ext;
    logic [OW-1:0]                  w_cap;

    rrc_pkg::t_probe                w_tok  [0:CAPACITY];
    logic                           w_vld  [0:CAPACITY];
    logic [SW-1:0]                  w_hslot[0:CAPACITY];

    logic                           w_tail_vld;
    logic                           w_append;
    logic                           w_evict;
    logic                           w_wr_en;
    logic [SW-1:0]                  w_wr_slot;
    logic [XW-1:0]                  w_slot_ext;

    // Effective capacity: zero acts as one, saturate at CAPACITY
    assign w_cfg_ext = CMP_W'(r_cap);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_cap_ext = CMP_W'(1);
        end else if (w_cfg_ext > CMP_W'(CAPACITY)) begin
            w_cap_ext = CMP_W'(CAPACITY);
        end else begin
            w_cap_ext = w_cfg_ext;
        end
    end
    assign w_cap = OW'(w_cap_ext);

    // Hold off configuration writes while reset is asserted
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= rrc_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrc_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = rrc_pkg::ST_MOD;
                end
            end
            rrc_pkg::ST_MOD: begin
                if (w_mod_done) begin
                    n_state = rrc_pkg::ST_WALK;
                end
            end
            rrc_pkg::ST_WALK: begin
                if (w_tail_vld) begin
                    n_state = rrc_pkg::ST_DONE;
                end
            end
            rrc_pkg::ST_DONE: begin
                if (!r_m_vld || i_m_axis_tready) begin
                    n_state = rrc_pkg::ST_IDLE;
                end
            end
            default: n_state = rrc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs; no item is taken while reset is asserted
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_launch        = 1'b0;
        w_out_load      = 1'b0;
        case (r_state)
            rrc_pkg::ST_IDLE: o_s_axis_tready = i_rst_n;
            rrc_pkg::ST_MOD:  w_launch        = w_mod_done;
            rrc_pkg::ST_WALK: ;
            rrc_pkg::ST_DONE: w_out_load      = !r_m_vld || i_m_axis_tready;
            default: ;
        endcase
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_s_axis_tdata[rrc_pkg::KEY_W-1:0];
        end
    end

    // Victim slot = draw mod effective capacity, ready before the probe launches
    rrc_mod #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_draw  (i_s_axis_tdata[rrc_pkg::KEY_W +: rrc_pkg::DRAW_W]),
        .i_cap   (w_cap),
        .o_done  (w_mod_done),
        .o_rem   (w_victim)
    );

    // Head of the chain: a fresh probe
    always_comb begin
        w_vld[0]              = w_launch;
        w_tok[0].hit          = 1'b0;
        w_tok[0].key          = r_key;
        w_tok[0].victim_key   = '0;
        w_hslot[0]            = '0;
    end

    // One cell per slot; the probe advances one cell per cycle
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        rrc_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_vld     (w_vld[g]),
            .i_tok     (w_tok[g]),
            .i_slot    (w_hslot[g]),
            .i_occ     (r_occ),
            .i_victim  (w_victim),
            .i_wr_en   (w_wr_en),
            .i_wr_slot (w_wr_slot),
            .i_wr_key  (r_key),
            .o_vld     (w_vld[g+1]),
            .o_tok     (w_tok[g+1]),
            .o_slot    (w_hslot[g+1])
        );
    end

    // Tail: decide hit / append / evict and write the key back
    assign w_tail_vld = w_vld[CAPACITY];
    assign w_append   = !w_tok[CAPACITY].hit && (r_occ < w_cap);
    assign w_evict    = !w_tok[CAPACITY].hit && !(r_occ < w_cap);
    assign w_wr_en    = w_tail_vld && !w_tok[CAPACITY].hit;
    assign w_wr_slot  = w_append ? r_occ[SW-1:0] : w_victim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (w_tail_vld && w_append) begin
            r_occ <= r_occ + 1'b1;
        end
    end

    // Hold the result until the output register frees up
    always_ff @(posedge i_clk) begin
        if (w_tail_vld) begin
            r_res_hit   <= w_tok[CAPACITY].hit;
            r_res_evict <= w_evict;
            r_res_evkey <= w_evict ? w_tok[CAPACITY].victim_key : '0;
            r_res_slot  <= w_tok[CAPACITY].hit ? w_hslot[CAPACITY] : w_wr_slot;
        end
    end

    assign w_slot_ext = XW'(r_res_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_out_load) begin
            r_m_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {2'b00, w_slot_ext[rrc_pkg::SLOT_OUT_W-1:0], r_res_evkey};
            r_m_user <= {r_res_evict, r_res_hit};
        end
    end

    assign o_m_axis_tvalid = r_m_vld;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    // Checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(CAPACITY))
        else $error("occupancy above CAPACITY");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_occ == $past(r_occ) || r_occ == $past(r_occ) + 1'b1))
        else $error("occupancy jumped");

    a_tail_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_vld |-> (r_state == rrc_pkg::ST_WALK))
        else $error("probe left the chain outside the walk");

    a_wr_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (OW'(w_wr_slot) < w_cap || w_append))
        else $error("write slot outside effective capacity");

    a_hit_xor_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrc_pkg::ST_DONE) |-> !(r_res_hit && r_res_evict))
        else $error("result flags both hit and evicted");

endmodule
